>>> sv/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types, constants and helpers for the BCD frequency frame parser.
// ----------------------------------------------------------------------------
package bfp_pkg;

   // Received byte history, newest byte at position 0
   localparam int HIST_DEPTH = 11;

   // Frame markers
   localparam logic [7:0] END_MARK = 8'hFD;
   localparam logic [7:0] PREAMBLE = 8'hFE;

   // Unanswered request counter saturates here
   localparam logic [2:0] COUNT_MAX = 3'd7;

   // Register reset values
   localparam logic [7:0] CTRL_ADDR_RESET = 8'hE0;
   localparam logic [2:0] MAX_UNANS_RESET = 3'd3;

   // Register map (index = paddr[2])
   localparam int          PADDR_W       = 3;
   localparam logic        REG_CTRL_ADDR = 1'b0;
   localparam logic        REG_MAX_UNANS = 1'b1;

   // BCD digit-pair weights, most significant pair first
   localparam logic [31:0] W_1E8 = 32'd100000000;
   localparam logic [31:0] W_1E6 = 32'd1000000;
   localparam logic [31:0] W_1E4 = 32'd10000;
   localparam logic [31:0] W_1E2 = 32'd100;

   // Frame kind codes
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_FOUR = 2'd1,
      KIND_FIVE = 2'd2
   } kind_type;

   typedef logic [7:0] byte_type;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [7:0] controller_address;
      logic [2:0] max_unanswered;
   } cfg_type;

   // One result beat
   typedef struct packed {
      kind_type    frame_kind;
      logic [31:0] freq_hz;
      logic [7:0]  radio_address;
      logic        available;
   } rsp_type;

   // Two BCD nibbles to their value (invalid nibbles weighted like digits)
   function automatic logic [7:0] bcd_pair(input logic [7:0] v);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {4'b0, v[7:4]};
      lo = {4'b0, v[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

endpackage

>>> sv/bfp_if.sv
// ----------------------------------------------------------------------------
// bfp_if
// Valid/ready channels for the request and result beats.
// ----------------------------------------------------------------------------
interface bfp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface bfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_kind;
   logic [31:0] freq_hz;
   logic [7:0]  radio_address;
   logic        available;

   modport source (output valid, output frame_kind, output freq_hz,
                   output radio_address, output available, input ready);
   modport sink   (input valid, input frame_kind, input freq_hz,
                   input radio_address, input available, output ready);
endinterface

>>> sv/bfp_csr.sv
// ----------------------------------------------------------------------------
// bfp_csr
// APB register block: controller address and unanswered request limit.
// ----------------------------------------------------------------------------
module bfp_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bfp_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output bfp_pkg::cfg_type            cfg
);
   import bfp_pkg::*;

   logic [7:0] ctrl_addr_ff;
   logic [7:0] ctrl_addr_in;
   logic [2:0] max_unans_ff;
   logic [2:0] max_unans_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Register write decode
   always_comb begin
      ctrl_addr_in = ctrl_addr_ff;
      max_unans_in = max_unans_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_CTRL_ADDR: ctrl_addr_in = pwdata[7:0];
            REG_MAX_UNANS: max_unans_in = pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_addr_ff <= CTRL_ADDR_RESET;
         max_unans_ff <= MAX_UNANS_RESET;
      end else begin
         ctrl_addr_ff <= ctrl_addr_in;
         max_unans_ff <= max_unans_in;
      end
   end

   // Read mux
   always_comb begin
      case (paddr[2])
         REG_CTRL_ADDR: prdata = {24'b0, ctrl_addr_ff};
         REG_MAX_UNANS: prdata = {29'b0, max_unans_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg.controller_address = ctrl_addr_ff;
   assign cfg.max_unanswered     = max_unans_ff;

endmodule

>>> sv/bfp_core.sv
// ----------------------------------------------------------------------------
// bfp_core
// Byte history, header match, BCD decode and request counter; one beat per
// step.
// ----------------------------------------------------------------------------
module bfp_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             cmd,
   input  logic [7:0]       rx_byte,
   input  bfp_pkg::cfg_type cfg,
   output bfp_pkg::rsp_type result
);
   import bfp_pkg::*;

   byte_type    hist_ff [HIST_DEPTH];
   byte_type    hist_in [HIST_DEPTH];
   logic [31:0] freq_ff;
   logic [31:0] freq_in;
   logic [7:0]  radio_ff;
   logic [7:0]  radio_in;
   logic [2:0]  count_ff;
   logic [2:0]  count_in;

   byte_type    h [HIST_DEPTH];
   logic        end_seen;
   logic        match5;
   logic        match4;
   logic [7:0]  p1, p2, p3, p4, p5;
   logic [31:0] f5;
   logic [31:0] f4;
   kind_type    kind;

   // History after this byte is shifted in
   always_comb begin
      h[0] = rx_byte;
      for (int i = 1; i < HIST_DEPTH; i++) begin
         h[i] = hist_ff[i-1];
      end
   end

   // Header checks
   assign end_seen = (h[0] == END_MARK);
   assign match5   = end_seen && (h[8] == cfg.controller_address) &&
                     (h[9] == PREAMBLE) && (h[10] == PREAMBLE);
   assign match4   = end_seen && (h[7] == cfg.controller_address) &&
                     (h[8] == PREAMBLE) && (h[9] == PREAMBLE);

   // BCD decode, constant weights, wraps mod 2^32
   assign p1 = bcd_pair(h[1]);
   assign p2 = bcd_pair(h[2]);
   assign p3 = bcd_pair(h[3]);
   assign p4 = bcd_pair(h[4]);
   assign p5 = bcd_pair(h[5]);

   assign f5 = 32'({24'b0, p1} * W_1E8) + 32'({24'b0, p2} * W_1E6) +
               32'({24'b0, p3} * W_1E4) + 32'({24'b0, p4} * W_1E2) +
               {24'b0, p5};
   assign f4 = 32'({24'b0, p1} * W_1E6) + 32'({24'b0, p2} * W_1E4) +
               32'({24'b0, p3} * W_1E2) + {24'b0, p4};

   // Next state; the four-byte form wins when both headers match
   always_comb begin
      hist_in  = hist_ff;
      freq_in  = freq_ff;
      radio_in = radio_ff;
      count_in = count_ff;
      kind     = KIND_NONE;
      if (cmd) begin
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 3'd1;
         end
      end else begin
         hist_in = h;
         if (match4) begin
            radio_in = h[6];
            freq_in  = f4;
            count_in = '0;
            kind     = KIND_FOUR;
         end else if (match5) begin
            radio_in = h[7];
            freq_in  = f5;
            count_in = '0;
            kind     = KIND_FIVE;
         end
      end
      // Stale frequency
      if (count_in > cfg.max_unanswered) begin
         freq_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         freq_ff  <= '0;
         radio_ff <= '0;
         count_ff <= '0;
      end else if (step) begin
         hist_ff  <= hist_in;
         freq_ff  <= freq_in;
         radio_ff <= radio_in;
         count_ff <= count_in;
      end
   end

   // Result beat for this step
   assign result.frame_kind    = kind;
   assign result.freq_hz       = freq_in;
   assign result.radio_address = radio_in;
   assign result.available     = (freq_in != '0) && (count_in <= cfg.max_unanswered);

   // A matched frame clears the request counter
   a_match_clears: assert property (@(posedge clock) disable iff (reset)
      step && (kind != KIND_NONE) |=> count_ff == '0)
      else $error("counter not cleared after frame match");

   // A request always leaves a nonzero count
   a_req_counts: assert property (@(posedge clock) disable iff (reset)
      step && cmd |=> count_ff != '0)
      else $error("request did not raise counter");

   // State holds between steps
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(freq_ff) && $stable(count_ff) && $stable(radio_ff))
      else $error("state changed without a step");

   // Stale frequency is zero after a step, unless the config has just changed
   a_stale_zero: assert property (@(posedge clock) disable iff (reset)
      count_ff > cfg.max_unanswered && $stable(cfg) |-> freq_ff == '0 ||
      !$past(step))
      else $error("stale frequency not cleared");

endmodule

>>> sv/bcd_frequency_frame_parser.sv
// ----------------------------------------------------------------------------
// bcd_frequency_frame_parser
// Parses frequency reply frames from a serial byte stream; top level.
// ----------------------------------------------------------------------------
// Each request beat is either a received byte (cmd 0) or a note that a
// frequency request went out (cmd 1), and produces exactly one result beat
// with the frame kind just completed, the stored frequency in Hz, the last
// radio address and an available flag. The block takes one beat per clock
// while the result output is not stalled: an input register feeds the byte
// history, header match and BCD decode, and a result register holds the
// answer; a stalled result only backs up the input register. Registers:
// controller_address at byte address 0 (reset 0xE0) and max_unanswered at 4
// (reset 3); write them only while no beat is in flight.
module bcd_frequency_frame_parser (
   input  logic                        clock,
   input  logic                        reset,
   bfp_req_if.sink                     req,
   bfp_rsp_if.source                   rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [bfp_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import bfp_pkg::*;

   cfg_type    cfg;
   rsp_type    result;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic       s1_cmd_ff;
   logic [7:0] s1_byte_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   rsp_type    out_ff;
   logic       req_take;
   logic       out_load;

   bfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bfp_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (out_load),
      .cmd     (s1_cmd_ff),
      .rx_byte (s1_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // Pipeline flow control
   assign out_load  = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || out_load;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff  <= req.cmd;
         s1_byte_ff <= req.rx_byte;
      end
      if (out_load) begin
         out_ff <= result;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.frame_kind    = out_ff.frame_kind;
   assign rsp.freq_hz       = out_ff.freq_hz;
   assign rsp.radio_address = out_ff.radio_address;
   assign rsp.available     = out_ff.available;

endmodule
